[design/assert_macros.svh]
// Assertion macros shared by the RTL of the reply frame deframer.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rfd_pkg.sv]
// Package for the reply frame deframer: sizes, reset values and codes.
// No dependencies.
`default_nettype none

package rfd_pkg;

	localparam int unsigned HEADER_LEN = 5;
	localparam int unsigned HDR_BYTES  = HEADER_LEN - 1;
	localparam int unsigned HDR_IDX_W  = $clog2(HDR_BYTES);
	localparam int unsigned CNT_W      = 3;

	localparam logic [7:0] START_BYTE_RESET  = 8'h76;
	localparam logic [7:0] MAX_PAYLOAD_RESET = 8'hFF;

	// result kinds
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// configuration register indexes (paddr[2])
	localparam logic REG_START_BYTE  = 1'b0;
	localparam logic REG_MAX_PAYLOAD = 1'b1;

	typedef logic [7:0] byte_t;
	typedef byte_t [HDR_BYTES-1:0] hdr_store_t;

endpackage

`default_nettype wire

[design/reply_frame_deframer_top.sv]
// Reply frame deframer, top level: hunt, header collection, payload pass-through.
// Depends on rfd_pkg and assert_macros.svh.
`default_nettype none

// The block takes one received byte per transaction and returns framed results.
// It drops bytes until one equals start_byte, then holds four header bytes
// (serial number, message id, status, payload length). A length no larger
// than max_payload yields one header result (kind 0, data 0) and then one
// result per payload byte (kind 1); last marks the final result of the frame,
// which is the header itself for a zero-length payload. An oversize length
// yields nothing: the start byte is dropped and the four held header bytes are
// rescanned, the first one equal to start_byte opening a new frame. Each byte
// is handled by the combinational logic between the state registers and the
// result register, so the block takes one byte every cycle and registers its
// result; the input stalls only while a finished result waits in the result
// register and the output side stalls. Configuration registers: start_byte at
// byte address 0 and max_payload at address 4; write them only while idle.
module reply_frame_deframer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB-style configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// received bytes
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	// results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic      [7:0]  serial_no,
	output logic      [7:0]  msg_id,
	output logic      [7:0]  status_byte,
	output logic      [7:0]  payload_len,
	output logic      [7:0]  data,
	output logic             last
);

	`include "assert_macros.svh"

	localparam int unsigned HDR_BYTES = rfd_pkg::HDR_BYTES;
	localparam int unsigned CNT_W     = rfd_pkg::CNT_W;
	localparam int unsigned IDX_W     = rfd_pkg::HDR_IDX_W;

	// configuration registers
	logic [7:0] start_byte_q;
	logic [7:0] max_payload_q;

	// deframer state
	rfd_pkg::hdr_store_t store_q, store_d;
	logic [CNT_W-1:0]    header_count_q, header_count_d;
	logic [7:0]          payload_left_q, payload_left_d;
	logic                in_payload_q, in_payload_d;

	// result register
	logic       out_valid_q;
	logic       kind_q, last_q;
	logic [7:0] data_q;
	rfd_pkg::hdr_store_t out_hdr_q;

	// combinational result of the current byte
	logic       res_valid, res_kind, res_last;
	logic [7:0] res_data;

	logic accept_in, cfg_write;
	logic payload_active, hunting, header_done, len_ok, rs_found;
	logic [CNT_W-1:0]    cnt_minus1, rs_count;
	logic [IDX_W-1:0]    wr_idx;
	logic [7:0]          hdr_len;
	rfd_pkg::hdr_store_t store_wr, rs_store;

	//------------------------------------------------------------------
	// Configuration port: always ready, register value read back.
	//------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= rfd_pkg::START_BYTE_RESET;
			max_payload_q <= rfd_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				rfd_pkg::REG_START_BYTE:  start_byte_q  <= pwdata[7:0];
				rfd_pkg::REG_MAX_PAYLOAD: max_payload_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rfd_pkg::REG_START_BYTE:  prdata = {24'd0, start_byte_q};
			rfd_pkg::REG_MAX_PAYLOAD: prdata = {24'd0, max_payload_q};
			default:                  prdata = 32'd0;
		endcase
	end

	//------------------------------------------------------------------
	// Handshake: hold the input only while a result waits and is stalled.
	//------------------------------------------------------------------
	assign in_stall  = out_valid_q && out_stall;
	assign accept_in = in_valid && !in_stall;

	//------------------------------------------------------------------
	// Byte processing.
	//------------------------------------------------------------------
	// A payload flag with nothing left counts as hunting.
	assign payload_active = in_payload_q && (payload_left_q != 8'd0);
	assign hunting        = (header_count_q == '0) ||
	                        (header_count_q > CNT_W'(HDR_BYTES));
	assign header_done    = (header_count_q == CNT_W'(HDR_BYTES));
	assign cnt_minus1     = header_count_q - CNT_W'(1);
	assign wr_idx         = cnt_minus1[IDX_W-1:0];

	// Header store with the current byte written at its slot.
	always_comb begin
		store_wr = store_q;
		if (!payload_active && !hunting) begin
			store_wr[wr_idx] = rx_byte;
		end
	end

	assign hdr_len = store_wr[HDR_BYTES-1];
	assign len_ok  = (hdr_len <= max_payload_q);

	// Rescan after an oversize length: the first held byte equal to the start
	// byte opens a new frame, and the bytes after it move to the front.
	always_comb begin
		rs_store = store_wr;
		rs_found = 1'b0;
		rs_count = '0;
		for (int p = 0; p < HDR_BYTES; p++) begin
			if (!rs_found && (store_wr[p] == start_byte_q)) begin
				rs_found = 1'b1;
				rs_count = CNT_W'(HDR_BYTES - p);
				for (int k = 0; k < HDR_BYTES - 1 - p; k++) begin
					rs_store[k] = store_wr[p + 1 + k];
				end
			end
		end
	end

	always_comb begin
		store_d        = store_q;
		header_count_d = header_count_q;
		payload_left_d = payload_left_q;
		in_payload_d   = in_payload_q;
		res_valid      = 1'b0;
		res_kind       = rfd_pkg::KIND_HEADER;
		res_data       = 8'd0;
		res_last       = 1'b0;
		if (payload_active) begin
			// pass the byte on; mark the final one
			res_valid      = 1'b1;
			res_kind       = rfd_pkg::KIND_PAYLOAD;
			res_data       = rx_byte;
			res_last       = (payload_left_q == 8'd1);
			payload_left_d = payload_left_q - 8'd1;
			in_payload_d   = (payload_left_q != 8'd1);
		end else begin
			in_payload_d = 1'b0;
			if (hunting) begin
				header_count_d = (rx_byte == start_byte_q) ? CNT_W'(1) : '0;
			end else begin
				store_d        = store_wr;
				header_count_d = header_count_q + CNT_W'(1);
				if (header_done) begin
					if (len_ok) begin
						header_count_d = '0;
						res_valid      = 1'b1;
						res_last       = (hdr_len == 8'd0);
						if (hdr_len != 8'd0) begin
							payload_left_d = hdr_len;
							in_payload_d   = 1'b1;
						end
					end else begin
						store_d        = rs_store;
						header_count_d = rs_found ? rs_count : '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q        <= '0;
			header_count_q <= '0;
			payload_left_q <= 8'd0;
			in_payload_q   <= 1'b0;
		end else if (accept_in) begin
			store_q        <= store_d;
			header_count_q <= header_count_d;
			payload_left_q <= payload_left_d;
			in_payload_q   <= in_payload_d;
		end
	end

	//------------------------------------------------------------------
	// Result register: load a new result, or drop the old one once taken.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept_in && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Header fields come from the store as it stands after this byte.
	always_ff @(posedge clk) begin
		if (accept_in && res_valid) begin
			kind_q    <= res_kind;
			data_q    <= res_data;
			last_q    <= res_last;
			out_hdr_q <= store_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign serial_no   = out_hdr_q[0];
	assign msg_id      = out_hdr_q[1];
	assign status_byte = out_hdr_q[2];
	assign payload_len = out_hdr_q[HDR_BYTES-1];
	assign data        = data_q;
	assign last        = last_q;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	`ASSERT_ALWAYS(a_payload_nonzero, !in_payload_q || (payload_left_q != 8'd0), "payload flag with nothing left")
	`ASSERT_ALWAYS(a_count_range, header_count_q <= CNT_W'(HDR_BYTES), "header count out of range")
	`ASSERT_ALWAYS(a_payload_not_header, !in_payload_q || (header_count_q == '0), "payload and header collection overlap")
	`ASSERT_ALWAYS(a_header_last, !out_valid_q || (kind_q != rfd_pkg::KIND_HEADER) || (last_q == (out_hdr_q[HDR_BYTES-1] == 8'd0)), "header last flag disagrees with length")
	`ASSERT_NEXT(a_final_byte, accept_in && payload_active && (payload_left_q == 8'd1), !in_payload_q && out_valid_q && last_q, "final payload byte did not close the frame")

endmodule

`default_nettype wire
